// ----- rtl/mrl_pkg.sv -----
// Shared types, constants and item layout for the monitor rectangle locator.
package mrl_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int COORD_W     = 16;
  localparam int EXT_W       = 18;   // coordinate sums and differences
  localparam int SQ_W        = 34;   // one squared difference
  localparam int DIST_W      = 35;   // sum of two squares
  localparam int DRAIN_W     = 2;
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd2;  // last value of the drain counter

  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 16'd1920;
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 16'd1080;

  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  // Input tdata layout
  localparam int IN_DATA_W     = 104;
  localparam int IN_RX_LSB     = 0;
  localparam int IN_RY_LSB     = 16;
  localparam int IN_RW_LSB     = 32;
  localparam int IN_RH_LSB     = 48;
  localparam int IN_RP_BIT     = 64;
  localparam int IN_PX_LSB     = 65;
  localparam int IN_PY_LSB     = 81;

  // Output tdata layout
  localparam int OUT_DATA_W    = 80;
  localparam int OUT_IDX_LSB   = 0;
  localparam int OUT_FX_LSB    = 4;
  localparam int OUT_FY_LSB    = 20;
  localparam int OUT_FW_LSB    = 36;
  localparam int OUT_FH_LSB    = 52;
  localparam int OUT_FP_BIT    = 68;
  localparam int OUT_CNT_LSB   = 69;
  localparam int OUT_ACC_BIT   = 74;

  typedef enum logic [1:0] {
    MODE_CLEAR   = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_LOCATE  = 2'd2,
    MODE_PRIMARY = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COORD_W-1:0]        w;
    logic [COORD_W-1:0]        h;
    logic                      primary;
  } entry_t;

  typedef struct packed {
    logic             capture;
    logic             exec;
    logic             scan_issue;
    logic [IDX_W-1:0] scan_idx;
    logic             rd_pick;
    logic             load_out;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  empty;
    logic  scan_last;
    logic  out_free;
  } status_t;

endpackage

// ----- rtl/monitor_rect_locator.sv -----
// Top level: monitor rectangle table with point location and primary lookup.
// Throughput: one item at a time; the next item is taken once the result sits
// in the output register. The locate scan reads one entry per cycle through the
// single table read port, then the drain state lets the distance compare
// finish before the picked entry is fetched.
// Reset (synchronous, rst high): table empty, no primary, screen 1920 x 1080.
module monitor_rect_locator (
  input  logic                            clk,
  input  logic                            rst,
  // input item
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: rect_x, rect_y, rect_width, rect_height, rect_primary, point_x, point_y
  input  logic [mrl_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: mode (0 clear, 1 append, 2 locate, 3 primary)
  input  logic [1:0]                      s_axis_tuser,
  // result item
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: entry_index, found_x, found_y, found_width, found_height,
  //        found_primary, entry_count, accepted
  output logic [mrl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // configuration: 0 screen_width, 1 screen_height
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [mrl_pkg::COORD_W-1:0]     cfg_data
);

  mrl_pkg::cmd_t    cmd;
  mrl_pkg::status_t status;

  // Sequencer owns the handshake on the input side and the scan index.
  mrl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  // Datapath holds the table, the distance pipeline and the result register.
  mrl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_data    (s_axis_tdata),
    .s_user    (s_axis_tuser),
    .m_valid   (m_axis_tvalid),
    .m_ready   (m_axis_tready),
    .m_data    (m_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ----- rtl/mrl_ctrl.sv -----
// Sequencer: takes an item, runs the table operation or scan, hands off the result.
module mrl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_valid,
  output logic            s_ready,
  input  mrl_pkg::status_t status,
  output mrl_pkg::cmd_t   cmd
);

  mrl_pkg::state_t              state, state_next;
  logic [mrl_pkg::IDX_W-1:0]    scan_idx, scan_idx_next;
  logic [mrl_pkg::DRAIN_W-1:0]  drain_cnt, drain_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mrl_pkg::ST_IDLE;
      scan_idx  <= '0;
      drain_cnt <= '0;
    end else begin
      state     <= state_next;
      scan_idx  <= scan_idx_next;
      drain_cnt <= drain_cnt_next;
    end
  end

  // next state
  always_comb begin
    state_next     = state;
    scan_idx_next  = scan_idx;
    drain_cnt_next = drain_cnt;
    case (state)
      mrl_pkg::ST_IDLE: begin
        if (s_valid) state_next = mrl_pkg::ST_EXEC;
      end
      mrl_pkg::ST_EXEC: begin
        scan_idx_next  = '0;
        drain_cnt_next = '0;
        if (status.mode inside {mrl_pkg::MODE_CLEAR, mrl_pkg::MODE_APPEND} || status.empty)
          state_next = mrl_pkg::ST_LOAD;
        else if (status.mode == mrl_pkg::MODE_LOCATE)
          state_next = mrl_pkg::ST_SCAN;
        else
          state_next = mrl_pkg::ST_FETCH;
      end
      mrl_pkg::ST_SCAN: begin
        scan_idx_next = scan_idx + 1'b1;
        if (status.scan_last) state_next = mrl_pkg::ST_DRAIN;
      end
      mrl_pkg::ST_DRAIN: begin
        drain_cnt_next = drain_cnt + 1'b1;
        if (drain_cnt == mrl_pkg::DRAIN_LAST) state_next = mrl_pkg::ST_FETCH;
      end
      mrl_pkg::ST_FETCH: begin
        state_next = mrl_pkg::ST_LOAD;
      end
      mrl_pkg::ST_LOAD: begin
        if (status.out_free) state_next = mrl_pkg::ST_IDLE;
      end
      default: begin
        state_next = mrl_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    s_ready        = 1'b0;
    cmd            = '0;
    cmd.scan_idx   = scan_idx;
    case (state)
      mrl_pkg::ST_IDLE: begin
        s_ready     = 1'b1;
        cmd.capture = s_valid;
      end
      mrl_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      mrl_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
      end
      mrl_pkg::ST_FETCH: begin
        cmd.rd_pick = 1'b1;
      end
      mrl_pkg::ST_LOAD: begin
        cmd.rd_pick  = 1'b1;
        cmd.load_out = status.out_free;
      end
      default: begin
        s_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/mrl_datapath.sv -----
// Rectangle table, scan pipeline, primary tracking and output register.
module mrl_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mrl_pkg::IN_DATA_W-1:0]   s_data,
  input  logic [1:0]                      s_user,
  output logic                            m_valid,
  input  logic                            m_ready,
  output logic [mrl_pkg::OUT_DATA_W-1:0]  m_data,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [mrl_pkg::COORD_W-1:0]     cfg_data,
  input  mrl_pkg::cmd_t                   cmd,
  output mrl_pkg::status_t                status
);

  localparam int CW = mrl_pkg::COORD_W;
  localparam int IW = mrl_pkg::IDX_W;
  localparam int NW = mrl_pkg::CNT_W;
  localparam int EW = mrl_pkg::EXT_W;

  // configuration
  logic [CW-1:0] screen_w, screen_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_w <= mrl_pkg::SCREEN_WIDTH_RST;
      screen_h <= mrl_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_index == mrl_pkg::CFG_SCREEN_WIDTH) screen_w <= cfg_data;
      else                                        screen_h <= cfg_data;
    end
  end

  // latched item
  mrl_pkg::mode_t        mode_q;
  logic signed [CW-1:0]  rx_q, ry_q, px_q, py_q;
  logic [CW-1:0]         rw_q, rh_q;
  logic                  rp_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mrl_pkg::mode_t'(s_user);
      rx_q   <= s_data[mrl_pkg::IN_RX_LSB +: CW];
      ry_q   <= s_data[mrl_pkg::IN_RY_LSB +: CW];
      rw_q   <= s_data[mrl_pkg::IN_RW_LSB +: CW];
      rh_q   <= s_data[mrl_pkg::IN_RH_LSB +: CW];
      rp_q   <= s_data[mrl_pkg::IN_RP_BIT];
      px_q   <= s_data[mrl_pkg::IN_PX_LSB +: CW];
      py_q   <= s_data[mrl_pkg::IN_PY_LSB +: CW];
    end
  end

  // table state
  mrl_pkg::entry_t table_mem [mrl_pkg::MAX_ENTRIES];
  mrl_pkg::entry_t rd_q, wr_entry;
  logic [NW-1:0]   stored_count;
  logic            prim_present;
  logic [IW-1:0]   prim_idx, eff_prim;
  logic            append_ok, acc_q;
  logic [IW-1:0]   pick_idx, rd_addr;

  assign append_ok = (mode_q == mrl_pkg::MODE_APPEND) && (rw_q != '0) && (rh_q != '0)
                     && (stored_count < NW'(mrl_pkg::MAX_ENTRIES));
  assign eff_prim  = prim_present ? prim_idx : '0;

  always_comb begin
    wr_entry.x       = rx_q;
    wr_entry.y       = ry_q;
    wr_entry.w       = rw_q;
    wr_entry.h       = rh_q;
    wr_entry.primary = rp_q && !prim_present;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && append_ok) table_mem[stored_count[IW-1:0]] <= wr_entry;
    rd_q <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      prim_present <= 1'b0;
    end else if (cmd.exec) begin
      if (mode_q == mrl_pkg::MODE_CLEAR) begin
        stored_count <= '0;
        prim_present <= 1'b0;
      end else if (append_ok) begin
        stored_count <= stored_count + 1'b1;
        if (wr_entry.primary) prim_present <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_q <= append_ok;
      if (append_ok && wr_entry.primary) prim_idx <= stored_count[IW-1:0];
    end
  end

  // scan pipeline: read, edge compare / centre offset, square, distance compare
  logic            v1, v2, v3;
  logic [IW-1:0]   idx1, idx2, idx3;
  logic            hit2, hit3;
  logic signed [EW-1:0] dx2, dy2;
  logic [mrl_pkg::SQ_W-1:0] sqx3, sqy3;

  logic signed [EW-1:0] px_e, py_e, x_e, y_e, right_e, bottom_e, cx_e, cy_e;
  logic signed [2*EW-1:0] dxx, dyy;
  logic [mrl_pkg::DIST_W-1:0] dist3;
  logic in_rect;

  always_comb begin
    px_e     = {{(EW-CW){px_q[CW-1]}}, px_q};
    py_e     = {{(EW-CW){py_q[CW-1]}}, py_q};
    x_e      = {{(EW-CW){rd_q.x[CW-1]}}, rd_q.x};
    y_e      = {{(EW-CW){rd_q.y[CW-1]}}, rd_q.y};
    right_e  = x_e + $signed({{(EW-CW){1'b0}}, rd_q.w});
    bottom_e = y_e + $signed({{(EW-CW){1'b0}}, rd_q.h});
    cx_e     = x_e + $signed({{(EW-CW+1){1'b0}}, rd_q.w[CW-1:1]});
    cy_e     = y_e + $signed({{(EW-CW+1){1'b0}}, rd_q.h[CW-1:1]});
    in_rect  = (px_e >= x_e) && (px_e < right_e) && (py_e >= y_e) && (py_e < bottom_e);
    dxx      = dx2 * dx2;
    dyy      = dy2 * dy2;
    dist3    = {1'b0, sqx3} + {1'b0, sqy3};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.scan_issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    idx1 <= cmd.scan_idx;
    idx2 <= idx1;
    hit2 <= in_rect;
    dx2  <= px_e - cx_e;
    dy2  <= py_e - cy_e;
    idx3 <= idx2;
    hit3 <= hit2;
    sqx3 <= dxx[mrl_pkg::SQ_W-1:0];
    sqy3 <= dyy[mrl_pkg::SQ_W-1:0];
  end

  // first hit and nearest centre
  logic                       hit_found, best_valid;
  logic [IW-1:0]              hit_idx, best_idx;
  logic [mrl_pkg::DIST_W-1:0] best_d;

  always_ff @(posedge clk) begin
    if (rst || cmd.exec) begin
      hit_found  <= 1'b0;
      best_valid <= 1'b0;
    end else if (v3) begin
      if (hit3 && !hit_found) hit_found <= 1'b1;
      if (!best_valid || dist3 < best_d) best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v3) begin
      if (hit3 && !hit_found) hit_idx <= idx3;
      if (!best_valid || dist3 < best_d) begin
        best_d   <= dist3;
        best_idx <= idx3;
      end
    end
  end

  assign pick_idx = (mode_q == mrl_pkg::MODE_LOCATE) ? (hit_found ? hit_idx : best_idx)
                                                     : eff_prim;
  assign rd_addr  = cmd.rd_pick ? pick_idx : cmd.scan_idx;

  // status
  always_comb begin
    status.mode      = mode_q;
    status.empty     = (stored_count == '0);
    status.scan_last = ((NW'(cmd.scan_idx) + NW'(1)) == stored_count);
    status.out_free  = !m_valid || m_ready;
  end

  // result assembly and output register
  logic [IW-1:0] o_idx;
  logic [CW-1:0] o_x, o_y, o_w, o_h;
  logic          o_p, o_acc;

  always_comb begin
    o_idx = '0;
    o_x   = '0;
    o_y   = '0;
    o_w   = '0;
    o_h   = '0;
    o_p   = 1'b0;
    o_acc = 1'b0;
    case (mode_q)
      mrl_pkg::MODE_CLEAR: begin
        o_acc = 1'b0;
      end
      mrl_pkg::MODE_APPEND: begin
        o_acc = acc_q;
      end
      default: begin
        if (stored_count == '0) begin
          o_w = screen_w;
          o_h = screen_h;
          o_p = 1'b1;
        end else begin
          o_idx = pick_idx;
          o_x   = rd_q.x;
          o_y   = rd_q.y;
          o_w   = rd_q.w;
          o_h   = rd_q.h;
          o_p   = (pick_idx == eff_prim);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.load_out) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_data <= {5'b0, o_acc, stored_count, o_p, o_h, o_w, o_y, o_x, o_idx};
    end
  end

endmodule

// ----- rtl/mrl_checker.sv -----
// Port-level checks for the monitor rectangle locator, bound to the top level.
module mrl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mrl_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  // one item in flight: no second accept right after one
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an accepted append leaves at least one entry
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[mrl_pkg::OUT_ACC_BIT]
      |-> m_axis_tdata[mrl_pkg::OUT_CNT_LSB +: mrl_pkg::CNT_W] != '0)
    else $error("accepted append with empty table");

  // entry count never exceeds the table size
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid
      |-> m_axis_tdata[mrl_pkg::OUT_CNT_LSB +: mrl_pkg::CNT_W] <= mrl_pkg::CNT_W'(mrl_pkg::MAX_ENTRIES))
    else $error("entry count out of range");

  // an accepted append reports index zero and no rectangle
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[mrl_pkg::OUT_ACC_BIT]
      |-> m_axis_tdata[mrl_pkg::OUT_FP_BIT:0] == '0)
    else $error("append result carries rectangle fields");

endmodule

bind monitor_rect_locator mrl_checker u_mrl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
